[design/bitmap_slot_allocator_unit_defines.svh]
// Assertion macros for the bitmap slot allocator checker.
// Depends on: nothing; expects clk_i and rst_ni in the using scope.
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define BSA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsa assertion failed");

// Next-cycle implication, disabled in reset.
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsa assertion failed");

`endif

[design/bsa_pkg.sv]
// Package for the bitmap slot allocator: sizes, codes and beat types.
// Depends on: nothing.
package bsa_pkg;

  localparam int TOTAL_SLOTS = 1024;
  localparam int MAX_BATCH = 16;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int NWORDS    = (TOTAL_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WCNT_W    = $clog2(NWORDS + 1);
  localparam int BUF_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int FOUND_W   = $clog2(MAX_BATCH + 1);
  localparam int SLOT_W    = WIDX_W + BIT_W;

  // Action codes
  localparam logic [3:0] ACT_ALLOC   = 4'd0;
  localparam logic [3:0] ACT_FREE    = 4'd1;
  localparam logic [3:0] ACT_RESET   = 4'd2;
  localparam logic [3:0] ACT_LOWEST  = 4'd3;
  localparam logic [3:0] ACT_HIGHEST = 4'd4;
  localparam logic [3:0] ACT_TEST    = 4'd5;
  localparam logic [3:0] ACT_SET     = 4'd6;
  localparam logic [3:0] ACT_CLEAR   = 4'd7;
  localparam logic [3:0] ACT_RANGE   = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic [3:0]  action;
    logic [9:0]  slot;
    logic [4:0]  count;
    logic [10:0] limit;
    logic [3:0]  rng_first;
    logic [4:0]  rng_words;
  } bsa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot_out;
    logic        flag;
    logic [10:0] free_slots;
    logic        last;
  } bsa_rsp_t;

  // Bitmap write and re-init control
  typedef struct packed {
    logic              init;
    logic [10:0]       act;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_idx;
    logic [WORD_W-1:0] wr_data;
  } bsa_map_ctl_t;

endpackage

[design/bsa_bitscan.sv]
// Shared bit scan unit: lowest and highest set bit of one bitmap word.
// Depends on: bsa_pkg.
module bsa_bitscan
  import bsa_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  output logic [BIT_W-1:0]  lo_o,
  output logic [BIT_W-1:0]  hi_o,
  output logic              nz_o
);

  // Priority encoders in both directions
  always_comb begin
    lo_o = '0;
    hi_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word_i[i]) lo_o = BIT_W'(i);
    end
    for (int i = 0; i < WORD_W; i++) begin
      if (word_i[i]) hi_o = BIT_W'(i);
    end
  end

  assign nz_o = |word_i;

endmodule

[design/bsa_map.sv]
// Used-slot bitmap: word registers with one read and one write port and re-init.
// Depends on: bsa_pkg.
module bsa_map
  import bsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsa_map_ctl_t      ctl_i,
  input  logic [WIDX_W-1:0] rd_idx_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] words_q [NWORDS];

  // Initial word: slots at or above act are marked used
  function automatic logic [WORD_W-1:0] init_word(input int w, input int act);
    int lo;
    int sh;
    lo = w * WORD_W;
    sh = act - lo;
    if (act >= lo + WORD_W) return '0;
    else if (act <= lo) return '1;
    else return {WORD_W{1'b1}} << sh[BIT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NWORDS; w++) words_q[w] <= init_word(w, TOTAL_SLOTS);
    end else if (ctl_i.init) begin
      for (int w = 0; w < NWORDS; w++) words_q[w] <= init_word(w, int'(ctl_i.act));
    end else if (ctl_i.wr_en) begin
      words_q[ctl_i.wr_idx] <= ctl_i.wr_data;
    end
  end

  assign rd_data_o = words_q[rd_idx_i];

endmodule

[design/bitmap_slot_allocator_unit.sv]
// Bitmap slot allocator top level: sequencer, hint, free count and result register.
// Depends on: bsa_pkg, bsa_map, bsa_bitscan.
//
// Usage:
//   An item is taken when start is high and busy is low; its fields come on req_i.
//   Results appear on rsp_o, each marked by done_o high for one cycle; rsp_o.last
//   marks the final beat of an item. The receiver cannot stall; results simply go.
//   cfg_we_i writes the active slot count from cfg_wdata_i; the user must write it
//   only while the block is idle, as the block itself does not enforce this.
// Throughput:
//   Free, reset, test, set, clear, unknown actions, trivial allocs and failed or
//   empty range items give their result the cycle after the item is taken, and
//   busy stays low: one per cycle. Lowest, highest and range queries read one
//   bitmap word per cycle. Allocation visits words in turn in a load step, claims
//   their free bits one at a time, then commits each word. The first pass runs
//   from the hint to the limit word, the wrap pass from word 0 up to the lower
//   of the two, and the item ends with one slot per beat. The single map read
//   port and the shared bit scan unit make the scans read words one at a time.
// Reset:
//   rst_ni clears the bitmap (slots at or above TOTAL_SLOTS used), the hint and
//   sets the free count and the active slot count to TOTAL_SLOTS.
module bitmap_slot_allocator_unit
  import bsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  bsa_req_t    req_i,
  output logic        done_o,
  output bsa_rsp_t    rsp_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_ALOAD, S_ACLAIM, S_EMIT, S_LOWEST, S_HIGHEST, S_RANGE
  } state_e;

  state_e              state_q, state_d;
  bsa_req_t            req_q, req_d;
  logic [10:0]         cfg_q;
  logic [WCNT_W-1:0]   w_q, w_d, stop_q, stop_d, lw_q, lw_d, hint_q, hint_d;
  logic [BIT_W-1:0]    tail_q, tail_d;
  logic [FOUND_W-1:0]  cnt_q, cnt_d, found_q, found_d;
  logic                pass_q, pass_d, empty_q, empty_d;
  logic [WORD_W-1:0]   fr_q, fr_d, claimed_q, claimed_d;
  logic [10:0]         free_q, free_d;
  logic [SLOT_W-1:0]   buf_q [MAX_BATCH];
  logic                buf_we;
  logic [SLOT_W-1:0]   buf_wdata;
  logic [BUF_W-1:0]    emit_q, emit_d;
  logic                done_q, done_d;
  bsa_rsp_t            rsp_q, rsp_d;

  logic [10:0]         act;
  logic [WCNT_W-1:0]   aw;
  logic [11:0]         aw_sum;
  bsa_map_ctl_t        map_ctl;
  logic [WIDX_W-1:0]   rd_idx;
  logic [WORD_W-1:0]   rd_data;
  logic [WORD_W-1:0]   scan_word;
  logic [BIT_W-1:0]    scan_lo, scan_hi;
  logic                scan_nz;
  logic [WORD_W-1:0]   tmask;
  logic [WORD_W-1:0]   hmask;
  logic                accept;

  // Effective active slot count
  always_comb begin
    if (cfg_q == '0) act = 11'd1;
    else if (cfg_q > 11'(TOTAL_SLOTS)) act = 11'(TOTAL_SLOTS);
    else act = cfg_q;
  end
  assign aw_sum = {1'b0, act} + 12'd63;
  assign aw     = aw_sum[BIT_W +: WCNT_W];

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Map read address: item slot when idle, scan word otherwise
  assign rd_idx = (state_q == S_IDLE) ? req_i.slot[SLOT_W-1:BIT_W] : w_q[WIDX_W-1:0];

  // Tail masks for the limit word and the last active word
  assign tmask = ((w_q == lw_q - WCNT_W'(1)) && (tail_q != '0)) ?
                 ~(({{(WORD_W-1){1'b0}}, 1'b1} << tail_q) - WORD_W'(1)) : '0;
  assign hmask = ((w_q == aw - WCNT_W'(1)) && (act[BIT_W-1:0] != '0)) ?
                 (({{(WORD_W-1){1'b0}}, 1'b1} << act[BIT_W-1:0]) - WORD_W'(1)) : '1;

  always_comb begin
    case (state_q)
      S_ACLAIM:  scan_word = fr_q;
      S_HIGHEST: scan_word = rd_data & hmask;
      default:   scan_word = rd_data;
    endcase
  end

  bsa_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (map_ctl),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  bsa_bitscan u_scan (
    .word_i (scan_word),
    .lo_o   (scan_lo),
    .hi_o   (scan_hi),
    .nz_o   (scan_nz)
  );

  // Sequencer
  always_comb begin
    logic [10:0]         ls;
    logic [11:0]         lw_sum;
    logic [WORD_W-1:0]   bmask;
    logic [WORD_W-1:0]   newword;
    logic [SLOT_W-1:0]   s;
    logic [FOUND_W-1:0]  cnt_sat;
    logic [WCNT_W-1:0]   lw_new;
    logic [WCNT_W:0]     rend;
    logic [10:0]         ft_dec;

    state_d   = state_q;
    req_d     = req_q;
    w_d       = w_q;
    stop_d    = stop_q;
    lw_d      = lw_q;
    hint_d    = hint_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    pass_d    = pass_q;
    empty_d   = empty_q;
    fr_d      = fr_q;
    claimed_d = claimed_q;
    free_d    = free_q;
    emit_d    = emit_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    buf_we    = 1'b0;
    buf_wdata = {w_q[WIDX_W-1:0], scan_lo};
    map_ctl   = '0;
    map_ctl.act    = act;
    map_ctl.wr_idx = rd_idx;

    ls      = (req_q.limit < act) ? req_q.limit : act;
    bmask   = {{(WORD_W-1){1'b0}}, 1'b1} << req_i.slot[BIT_W-1:0];
    newword = rd_data | claimed_q;
    s       = {w_q[WIDX_W-1:0], scan_lo};
    cnt_sat = '0;
    lw_new  = '0;
    lw_sum  = '0;
    rend    = '0;
    ft_dec  = (free_q != '0) ? free_q - 11'd1 : '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          rsp_d = '{status: ST_OK, slot_out: '0, flag: 1'b0, free_slots: free_q, last: 1'b1};
          case (req_i.action)
            ACT_ALLOC: begin
              ls      = (req_i.limit < act) ? req_i.limit : act;
              cnt_sat = (req_i.count > 5'(MAX_BATCH)) ? FOUND_W'(MAX_BATCH)
                                                      : FOUND_W'(req_i.count);
              lw_sum  = {1'b0, ls} + 12'd63;
              lw_new  = lw_sum[BIT_W +: WCNT_W];
              if (cnt_sat == '0 || ls == '0) begin
                rsp_d.status = ST_NONE;
                done_d       = 1'b1;
              end else begin
                cnt_d   = cnt_sat;
                lw_d    = lw_new;
                tail_d  = ls[BIT_W-1:0];
                pass_d  = 1'b0;
                w_d     = hint_q;
                stop_d  = lw_new;
                found_d = '0;
                state_d = S_ALOAD;
              end
            end
            ACT_FREE: begin
              done_d = 1'b1;
              if ({1'b0, req_i.slot} >= act) begin
                rsp_d.status = ST_RANGE;
              end else if ((rd_data & bmask) == '0) begin
                rsp_d.status = ST_DOUBLE;
              end else begin
                map_ctl.wr_en   = 1'b1;
                map_ctl.wr_data = rd_data & ~bmask;
                free_d = (free_q != 11'h7FF) ? free_q + 11'd1 : free_q;
                rsp_d.free_slots = free_d;
              end
            end
            ACT_RESET: begin
              done_d           = 1'b1;
              map_ctl.init     = 1'b1;
              hint_d           = '0;
              free_d           = act;
              rsp_d.free_slots = act;
            end
            ACT_LOWEST: begin
              w_d     = '0;
              state_d = S_LOWEST;
            end
            ACT_HIGHEST: begin
              w_d     = aw - WCNT_W'(1);
              state_d = S_HIGHEST;
            end
            ACT_TEST, ACT_SET, ACT_CLEAR: begin
              done_d = 1'b1;
              if ({1'b0, req_i.slot} >= 11'(TOTAL_SLOTS)) begin
                rsp_d.status = ST_RANGE;
              end else if (req_i.action == ACT_TEST) begin
                rsp_d.flag = ((rd_data & bmask) != '0);
              end else begin
                map_ctl.wr_en   = 1'b1;
                map_ctl.wr_data = (req_i.action == ACT_SET) ? (rd_data | bmask)
                                                            : (rd_data & ~bmask);
              end
            end
            ACT_RANGE: begin
              rend = (WCNT_W+1)'(req_i.rng_first) + (WCNT_W+1)'(req_i.rng_words);
              if (rend > (WCNT_W+1)'(NWORDS)) begin
                rsp_d.status = ST_RANGE;
                done_d       = 1'b1;
              end else if (req_i.rng_words == '0) begin
                rsp_d.flag = 1'b1;
                done_d     = 1'b1;
              end else begin
                w_d     = WCNT_W'(req_i.rng_first);
                stop_d  = rend[WCNT_W-1:0];
                empty_d = 1'b1;
                state_d = S_RANGE;
              end
            end
            default: begin
              rsp_d.status = ST_RANGE;
              done_d       = 1'b1;
            end
          endcase
        end
      end

      // Open the next word, move to the next pass or finish the item
      S_ALOAD: begin
        if (w_q >= stop_q) begin
          if (!pass_q) begin
            pass_d = 1'b1;
            w_d    = '0;
            stop_d = (hint_q < lw_q) ? hint_q : lw_q;
          end else if (found_q == '0) begin
            rsp_d = '{status: ST_NONE, slot_out: '0, flag: 1'b0, free_slots: free_q,
                      last: 1'b1};
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            emit_d  = '0;
            state_d = S_EMIT;
          end
        end else begin
          fr_d      = ~(rd_data | tmask);
          claimed_d = '0;
          state_d   = S_ACLAIM;
        end
      end

      // Claim one free bit per cycle, then commit the word
      S_ACLAIM: begin
        if (scan_nz && (found_q < cnt_q)) begin
          buf_we    = 1'b1;
          claimed_d = claimed_q | ({{(WORD_W-1){1'b0}}, 1'b1} << scan_lo);
          fr_d      = fr_q & ~({{(WORD_W-1){1'b0}}, 1'b1} << scan_lo);
          found_d   = found_q + FOUND_W'(1);
        end else begin
          if (claimed_q != '0) begin
            map_ctl.wr_en   = 1'b1;
            map_ctl.wr_data = newword;
            if ((newword | tmask) == '1) hint_d = w_q + WCNT_W'(1);
          end
          if (found_q == cnt_q) begin
            emit_d  = '0;
            state_d = S_EMIT;
          end else begin
            w_d     = w_q + WCNT_W'(1);
            state_d = S_ALOAD;
          end
        end
      end

      // One allocated slot per beat
      S_EMIT: begin
        free_d = ft_dec;
        done_d = 1'b1;
        rsp_d  = '{status: ST_OK, slot_out: 10'(buf_q[emit_q]), flag: 1'b0,
                   free_slots: ft_dec,
                   last: (FOUND_W'(emit_q) + FOUND_W'(1) == found_q)};
        if (FOUND_W'(emit_q) + FOUND_W'(1) == found_q) state_d = S_IDLE;
        else emit_d = emit_q + BUF_W'(1);
      end

      S_LOWEST: begin
        if (scan_nz) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (11'(s) < act) rsp_d.slot_out = 10'(s);
          else rsp_d.status = ST_NONE;
        end else if (w_q == aw - WCNT_W'(1)) begin
          done_d       = 1'b1;
          state_d      = S_IDLE;
          rsp_d.status = ST_NONE;
        end else begin
          w_d = w_q + WCNT_W'(1);
        end
      end

      S_HIGHEST: begin
        if (scan_nz) begin
          done_d         = 1'b1;
          state_d        = S_IDLE;
          rsp_d.slot_out = 10'({w_q[WIDX_W-1:0], scan_hi});
        end else if (w_q == '0) begin
          done_d       = 1'b1;
          state_d      = S_IDLE;
          rsp_d.status = ST_NONE;
        end else begin
          w_d = w_q - WCNT_W'(1);
        end
      end

      S_RANGE: begin
        empty_d = empty_q && !scan_nz;
        if (w_q + WCNT_W'(1) == stop_q) begin
          done_d     = 1'b1;
          state_d    = S_IDLE;
          rsp_d.flag = empty_q && !scan_nz;
        end else begin
          w_d = w_q + WCNT_W'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_q     <= 11'(TOTAL_SLOTS);
      hint_q    <= '0;
      free_q    <= 11'(TOTAL_SLOTS);
      done_q    <= 1'b0;
      req_q     <= '0;
      w_q       <= '0;
      stop_q    <= '0;
      lw_q      <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      found_q   <= '0;
      pass_q    <= 1'b0;
      empty_q   <= 1'b0;
      fr_q      <= '0;
      claimed_q <= '0;
      emit_q    <= '0;
      rsp_q     <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      hint_q    <= hint_d;
      free_q    <= free_d;
      done_q    <= done_d;
      req_q     <= req_d;
      w_q       <= w_d;
      stop_q    <= stop_d;
      lw_q      <= lw_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      pass_q    <= pass_d;
      empty_q   <= empty_d;
      fr_q      <= fr_d;
      claimed_q <= claimed_d;
      emit_q    <= emit_d;
      rsp_q     <= rsp_d;
    end
  end

  // Claimed slot buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_q[found_q[BUF_W-1:0]] <= buf_wdata;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[design/bsa_checker.sv]
// Port-level checker for the bitmap slot allocator, bound to the top level.
// Depends on: bsa_pkg, bitmap_slot_allocator_unit_defines.svh.
`include "bitmap_slot_allocator_unit_defines.svh"

module bsa_checker
  import bsa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        done_o,
  input bsa_rsp_t    rsp_o
);

  // More beats of the same item are still owed
  `BSA_ASSERT_SAME(a_pending_busy, done_o && !rsp_o.last, busy)
  // Error beats are always single
  `BSA_ASSERT_SAME(a_err_last, done_o && (rsp_o.status != ST_OK), rsp_o.last)
  // Batch beats come back to back
  `BSA_ASSERT_NEXT(a_batch_dense, done_o && !rsp_o.last, done_o)
  // Entering a long item never coincides with a beat
  `BSA_ASSERT_SAME(a_busy_rise, $rose(busy), !done_o)

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (.*);
